@@ rtl/itoa_pkg.sv @@
`default_nettype none

package itoa_pkg;

    // widths
    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int BITCNT_W   = $clog2(VALUE_BITS);
    localparam int DIGCNT_W   = $clog2(VALUE_BITS + 1);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // radix register limits
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);

    // register index, taken from paddr bit 2
    localparam logic REG_RADIX = 1'b0;

    // character codes
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A  = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS    = CHAR_W'(8'h2d);
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = CHAR_W'(10);
    localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = RADIX_W'(9);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // commands to the serial divider
    typedef struct packed {
        logic load;
        logic again;
    } div_cmd_t;

    // divider status, digit and q_zero valid while done is high
    typedef struct packed {
        logic               done;
        logic [RADIX_W-1:0] digit;
        logic               q_zero;
    } div_stat_t;

    // digit value to lower-case ascii
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d > DIGIT_MAX_DEC)
        begin
            return d_ext - LETTER_OFFSET + CHAR_LOWER_A;
        end
        return d_ext + CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

@@ rtl/itoa_cfg_regs.sv @@
`default_nettype none

module itoa_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [itoa_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [itoa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [itoa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic      [itoa_pkg::RADIX_W-1:0]     radix
);

    logic [itoa_pkg::RADIX_W-1:0] radix_reg;
    logic [itoa_pkg::RADIX_W-1:0] radix_next;
    logic [itoa_pkg::RADIX_W-1:0] wr_radix;
    logic                         wr_en;

    // write strobe for the radix register
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[2] == itoa_pkg::REG_RADIX);

    // clamp the written base into range
    always_comb
    begin
        wr_radix = pwdata[itoa_pkg::RADIX_W-1:0];
        if (wr_radix < itoa_pkg::RADIX_MIN)
        begin
            wr_radix = itoa_pkg::RADIX_MIN;
        end
        else if (wr_radix > itoa_pkg::RADIX_MAX)
        begin
            wr_radix = itoa_pkg::RADIX_MAX;
        end
        radix_next = wr_en ? wr_radix : radix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itoa_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == itoa_pkg::REG_RADIX)
        begin
            prdata = itoa_pkg::APB_DATA_W'(radix_reg);
        end
    end

    assign radix = radix_reg;

endmodule

`default_nettype wire

@@ rtl/itoa_serial_div.sv @@
`default_nettype none

module itoa_serial_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire itoa_pkg::div_cmd_t                cmd,
    input  wire logic [itoa_pkg::VALUE_BITS-1:0]   dividend,
    input  wire logic [itoa_pkg::RADIX_W-1:0]      radix,
    output itoa_pkg::div_stat_t                    stat
);

    localparam logic [itoa_pkg::BITCNT_W-1:0] BIT_LAST =
        itoa_pkg::BITCNT_W'(itoa_pkg::VALUE_BITS - 1);

    logic [itoa_pkg::VALUE_BITS-1:0] quo_reg;
    logic [itoa_pkg::VALUE_BITS-1:0] quo_next;
    logic [itoa_pkg::RADIX_W-1:0]    rem_reg;
    logic [itoa_pkg::RADIX_W-1:0]    rem_next;
    logic [itoa_pkg::BITCNT_W-1:0]   cnt_reg;
    logic [itoa_pkg::BITCNT_W-1:0]   cnt_next;
    logic                            run_reg;
    logic                            run_next;
    logic                            nz_reg;
    logic                            nz_next;
    logic                            done_reg;
    logic                            done_next;
    logic [itoa_pkg::RADIX_W:0]      trial;
    logic [itoa_pkg::RADIX_W:0]      diff;
    logic                            q_bit;

    // one restoring step: bring in the next dividend bit, try to subtract
    assign trial = {rem_reg, quo_reg[itoa_pkg::VALUE_BITS-1]};
    assign diff  = trial - {1'b0, radix};
    assign q_bit = (trial >= {1'b0, radix});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        nz_next   = nz_reg;
        done_next = run_reg && (cnt_reg == BIT_LAST);
        if (cmd.load || cmd.again)
        begin
            if (cmd.load)
            begin
                quo_next = dividend;
            end
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
            nz_next  = 1'b0;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[itoa_pkg::VALUE_BITS-2:0], q_bit};
            rem_next = q_bit ? diff[itoa_pkg::RADIX_W-1:0] : trial[itoa_pkg::RADIX_W-1:0];
            nz_next  = nz_reg || q_bit;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_LAST)
            begin
                run_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            nz_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            nz_reg   <= nz_next;
            done_reg <= done_next;
        end
    end

    // quotient and remainder shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.done   = done_reg;
    assign stat.digit  = rem_reg;
    assign stat.q_zero = !nz_reg;

endmodule

`default_nettype wire

@@ rtl/itoa_digit_stack.sv @@
`default_nettype none

module itoa_digit_stack (
    input  wire logic                          clk,
    input  wire logic                          push,
    input  wire logic                          pop,
    input  wire logic [itoa_pkg::RADIX_W-1:0]  push_digit,
    output logic      [itoa_pkg::RADIX_W-1:0]  top_digit
);

    logic [itoa_pkg::RADIX_W-1:0] stack_reg  [itoa_pkg::VALUE_BITS];
    logic [itoa_pkg::RADIX_W-1:0] stack_next [itoa_pkg::VALUE_BITS];

    // push shifts down from the top, pop shifts up towards it
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::VALUE_BITS; i++)
        begin
            stack_next[i] = stack_reg[i];
        end
        if (push)
        begin
            stack_next[0] = push_digit;
            for (int i = 1; i < itoa_pkg::VALUE_BITS; i++)
            begin
                stack_next[i] = stack_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < itoa_pkg::VALUE_BITS - 1; i++)
            begin
                stack_next[i] = stack_reg[i+1];
            end
            stack_next[itoa_pkg::VALUE_BITS-1] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < itoa_pkg::VALUE_BITS; i++)
        begin
            stack_reg[i] <= stack_next[i];
        end
    end

    assign top_digit = stack_reg[0];

endmodule

`default_nettype wire

@@ rtl/integer_to_radix_ascii.sv @@
// Integer to radix text converter.
// A word is offered on value with start high; it is taken at the clock edge
// where start is high and busy is low, and busy stays high until the last
// character has been sent. The text comes out on ascii_char, most
// significant character first, one character per cycle with strobe high;
// last_char marks the final character of the number. In base ten a negative
// value is sent as '-' and its magnitude; in other bases its 32-bit pattern
// is converted unsigned. The base is set through the register port at
// address 0 (clamped to 2..36) and must only be written while busy is low.
// Each digit costs one pass of a bit-serial divider over all 32 bits of the
// dividend plus a handover of the digit to the digit stack; after the last
// digit a minus sign is sent if needed, then the digits are output. Zero
// gives a single '0'. Results are shown for one cycle only and the receiver
// has no way to hold them off. Reset sets the base to ten and returns to idle.
`default_nettype none

module integer_to_radix_ascii (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic        [itoa_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic        [itoa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic             [itoa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                         pready,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic signed [itoa_pkg::VALUE_BITS-1:0]  value,
    output logic                                         strobe,
    output logic             [itoa_pkg::CHAR_W-1:0]      ascii_char,
    output logic                                         last_char
);

    localparam logic [itoa_pkg::DIGCNT_W-1:0] ONE_DIGIT = itoa_pkg::DIGCNT_W'(1);

    itoa_pkg::state_t             state_reg;
    itoa_pkg::state_t             state_next;
    logic                         neg_reg;
    logic                         neg_next;
    logic [itoa_pkg::DIGCNT_W-1:0] ndig_reg;
    logic [itoa_pkg::DIGCNT_W-1:0] ndig_next;

    logic [itoa_pkg::RADIX_W-1:0]    radix;
    logic [itoa_pkg::VALUE_BITS-1:0] value_bits;
    logic [itoa_pkg::VALUE_BITS-1:0] dividend;
    logic                            accept;
    logic                            in_neg;
    itoa_pkg::div_cmd_t              div_cmd;
    itoa_pkg::div_stat_t             div_stat;
    logic                            push;
    logic                            pop;
    logic [itoa_pkg::RADIX_W-1:0]    top_digit;

    // configuration register
    itoa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radix   (radix)
    );

    // sign handling on the incoming word
    assign accept     = start && !busy;
    assign value_bits = value;
    assign in_neg     = (radix == itoa_pkg::RADIX_DEC) && value_bits[itoa_pkg::VALUE_BITS-1];
    assign dividend   = in_neg ? (~value_bits + 1'b1) : value_bits;

    // serial divider, one digit per pass
    itoa_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (dividend),
        .radix    (radix),
        .stat     (div_stat)
    );

    // digits arrive least significant first and leave most significant first
    itoa_digit_stack u_stack (
        .clk        (clk),
        .push       (push),
        .pop        (pop),
        .push_digit (div_stat.digit),
        .top_digit  (top_digit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        ndig_next  = ndig_reg;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = itoa_pkg::ST_DIVIDE;
                    neg_next   = in_neg;
                    ndig_next  = '0;
                end
            end
            itoa_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    ndig_next = ndig_reg + 1'b1;
                    if (div_stat.q_zero)
                    begin
                        state_next = neg_reg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
                    end
                end
            end
            itoa_pkg::ST_SIGN:
            begin
                state_next = itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_EMIT:
            begin
                ndig_next = ndig_reg - 1'b1;
                if (ndig_reg == ONE_DIGIT)
                begin
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::ST_IDLE;
            neg_reg   <= 1'b0;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
            ndig_reg  <= ndig_next;
        end
    end

    // outputs and unit commands
    always_comb
    begin
        busy          = 1'b1;
        strobe        = 1'b0;
        ascii_char    = itoa_pkg::CHAR_ZERO;
        last_char     = 1'b0;
        div_cmd.load  = 1'b0;
        div_cmd.again = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                busy         = 1'b0;
                div_cmd.load = start;
            end
            itoa_pkg::ST_DIVIDE:
            begin
                push          = div_stat.done;
                div_cmd.again = div_stat.done && !div_stat.q_zero;
            end
            itoa_pkg::ST_SIGN:
            begin
                strobe     = 1'b1;
                ascii_char = itoa_pkg::CHAR_MINUS;
            end
            itoa_pkg::ST_EMIT:
            begin
                strobe     = 1'b1;
                pop        = 1'b1;
                ascii_char = itoa_pkg::digit_to_char(top_digit);
                last_char  = (ndig_reg == ONE_DIGIT);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // checks
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character sent while idle");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |=> !busy)
        else $error("still busy after last character");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start a conversion");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && ascii_char == itoa_pkg::CHAR_MINUS) |-> !last_char)
        else $error("minus sign marked as last character");

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itoa_pkg::ST_EMIT) |-> (ndig_reg != '0))
        else $error("digit stack empty while sending");

endmodule

`default_nettype wire

@@ tb/tb_integer_to_radix_ascii.sv @@
`default_nettype none

module tb_integer_to_radix_ascii;

    import itoa_pkg::*;

    // byte addresses on the register port
    localparam logic [APB_ADDR_W-1:0] ADDR_RADIX  = {REG_RADIX, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = {~REG_RADIX, 2'b00};

    // idle cycles seen before the base may be rewritten
    localparam int IDLE_SETTLE = 4;
    // cycles watched after the last character, above one digit of division
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_SHOWN   = 10;

    typedef enum logic [1:0] {
        JOB_WORD,
        JOB_RADIX,
        JOB_DRAIN,
        JOB_PACE
    } job_kind_t;

    typedef enum logic [1:0] {
        BUS_IDLE,
        BUS_SETUP,
        BUS_ACCESS
    } bus_phase_t;

    typedef struct {
        job_kind_t                kind;
        logic [APB_ADDR_W-1:0]    addr;
        logic [31:0]              data;
    } job_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic                   clk     = 1'b0;
    logic                   rst_n   = 1'b0;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr   = '0;
    logic [APB_DATA_W-1:0]  pwdata  = '0;
    wire  [APB_DATA_W-1:0]  prdata;
    wire                    pready;
    logic                   start   = 1'b0;
    wire                    busy;
    logic [VALUE_BITS-1:0]  value   = '0;
    wire                    strobe;
    wire  [CHAR_W-1:0]      ascii_char;
    wire                    last_char;

    job_t          work_list[$];
    text_char_t    pending_chars[$];
    logic [RADIX_W-1:0] base_now = RADIX_RESET;
    bus_phase_t    bus_phase    = BUS_IDLE;
    int            gap_pct      = 0;
    int            quiet_cycles = 0;
    int            fault_count  = 0;

    integer_to_radix_ascii u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

    always #2 clk = ~clk;

    // text of one word in the current base, queued character by character
    function automatic void predict_text(input logic [31:0] word,
                                         input logic [RADIX_W-1:0] base);
        logic [31:0]       mag;
        logic [31:0]       digit;
        logic [CHAR_W-1:0] digs[$];
        logic              neg;
        text_char_t        tc;
        neg = (base == RADIX_DEC) && word[31];
        mag = neg ? (32'd0 - word) : word;
        if (mag == 32'd0)
        begin
            digs.push_front(CHAR_ZERO);
        end
        while (mag != 32'd0)
        begin
            digit = mag % 32'(base);
            if (digit > 32'(DIGIT_MAX_DEC))
            begin
                digs.push_front(CHAR_W'(digit) - LETTER_OFFSET + CHAR_LOWER_A);
            end
            else
            begin
                digs.push_front(CHAR_W'(digit) + CHAR_ZERO);
            end
            mag = mag / 32'(base);
        end
        if (neg)
        begin
            tc.ch   = CHAR_MINUS;
            tc.last = 1'b0;
            pending_chars.insert(pending_chars.size(), tc);
        end
        foreach (digs[i])
        begin
            tc.ch   = digs[i];
            tc.last = (i == digs.size() - 1);
            pending_chars.insert(pending_chars.size(), tc);
        end
    endfunction

    // base register: six bits kept, clamped to 2..36, other index ignored
    function automatic void write_base(input logic [APB_ADDR_W-1:0] addr,
                                       input logic [31:0] data);
        logic [RADIX_W-1:0] w;
        w = data[RADIX_W-1:0];
        if (addr[2] == REG_RADIX)
        begin
            if (w < RADIX_MIN)
            begin
                w = RADIX_MIN;
            end
            else if (w > RADIX_MAX)
            begin
                w = RADIX_MAX;
            end
            base_now = w;
        end
    endfunction

    task automatic note_fault(input string what, input text_char_t want,
                              input text_char_t got);
        fault_count++;
        if (fault_count <= MAX_SHOWN)
        begin
            $display("%s: expected char %h last %b, got char %h last %b",
                     what, want.ch, want.last, got.ch, got.last);
        end
    endtask

    function automatic void add_job(input job_kind_t kind,
                                    input logic [APB_ADDR_W-1:0] addr,
                                    input logic [31:0] data);
        job_t j;
        j.kind = kind;
        j.addr = addr;
        j.data = data;
        work_list.insert(work_list.size(), j);
    endfunction

    function automatic void add_word(input logic [31:0] w);
        add_job(JOB_WORD, ADDR_RADIX, w);
    endfunction

    function automatic void add_base(input logic [31:0] b);
        add_job(JOB_RADIX, ADDR_RADIX, b);
    endfunction

    // full-width words in four of ten draws, with short, negative and extreme ones mixed in
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(9))
            0, 1, 2, 3: w = $urandom;
            4, 5:       w = $urandom >> $urandom_range(31);
            6:          w = 32'd0 - ($urandom >> $urandom_range(31));
            7:          w = $urandom_range(40);
            8:          w = 32'h8000_0000 + $urandom_range(7);
            default:    w = 32'h7fff_ffff - $urandom_range(7);
        endcase
        return w;
    endfunction

    // driver: words on start, base writes on the register port when idle
    always @(posedge clk)
    begin : driver
        job_t                  job;
        logic                  start_n;
        logic                  psel_n;
        logic                  penable_n;
        logic                  pwrite_n;
        logic [31:0]           value_n;
        logic [APB_ADDR_W-1:0] paddr_n;
        logic [31:0]           pwdata_n;
        if (rst_n)
        begin
            start_n   = start;
            value_n   = value;
            psel_n    = psel;
            penable_n = penable;
            pwrite_n  = pwrite;
            paddr_n   = paddr;
            pwdata_n  = pwdata;

            // word taken at this edge
            if (start && !busy)
            begin
                predict_text(value, base_now);
                start_n = 1'b0;
            end

            if (!start && !busy && pending_chars.size() == 0)
            begin
                quiet_cycles++;
            end
            else
            begin
                quiet_cycles = 0;
            end

            case (bus_phase)
                BUS_SETUP:
                begin
                    penable_n = 1'b1;
                    bus_phase = BUS_ACCESS;
                end
                BUS_ACCESS:
                begin
                    if (pready)
                    begin
                        write_base(paddr, pwdata);
                        psel_n    = 1'b0;
                        penable_n = 1'b0;
                        pwrite_n  = 1'b0;
                        bus_phase = BUS_IDLE;
                    end
                end
                default:
                begin
                    if (!start_n && work_list.size() != 0)
                    begin
                        job = work_list[0];
                        case (job.kind)
                            JOB_WORD:
                            begin
                                if ($urandom_range(99) >= gap_pct)
                                begin
                                    void'(work_list.pop_front());
                                    start_n = 1'b1;
                                    value_n = job.data;
                                end
                            end
                            JOB_RADIX:
                            begin
                                if (quiet_cycles >= IDLE_SETTLE)
                                begin
                                    void'(work_list.pop_front());
                                    psel_n    = 1'b1;
                                    pwrite_n  = 1'b1;
                                    penable_n = 1'b0;
                                    paddr_n   = job.addr;
                                    pwdata_n  = job.data;
                                    bus_phase = BUS_SETUP;
                                end
                            end
                            JOB_DRAIN:
                            begin
                                if (quiet_cycles >= IDLE_SETTLE)
                                begin
                                    void'(work_list.pop_front());
                                end
                            end
                            default:
                            begin
                                void'(work_list.pop_front());
                                gap_pct = job.data;
                            end
                        endcase
                    end
                end
            endcase

            start   <= start_n;
            value   <= value_n;
            psel    <= psel_n;
            penable <= penable_n;
            pwrite  <= pwrite_n;
            paddr   <= paddr_n;
            pwdata  <= pwdata_n;
        end
    end

    // monitor: every strobed character against the oldest expectation
    always @(posedge clk)
    begin : monitor
        text_char_t want;
        text_char_t got;
        if (rst_n && strobe)
        begin
            got.ch   = ascii_char;
            got.last = last_char;
            if (pending_chars.size() == 0)
            begin
                want = '0;
                note_fault("unexpected character", want, got);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (got.ch !== want.ch || got.last !== want.last)
                begin
                    note_fault("mismatch", want, got);
                end
            end
        end
    end

    // slowest run: every word 32 binary digits
    initial
    begin
        #(4 * 3_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int n;
        int pace_list[3];
        int base_list[8];
        pace_list = '{0, 88, 35};
        base_list = '{2, 36, 10, 0, 63, 16, 8, 2};

        // reset base of ten, sign handling and both extremes
        add_word(32'd0);
        add_word(32'd1);
        add_word(32'hffff_ffff);
        add_word(32'd9);
        add_word(32'd10);
        add_word(32'hffff_fff6);
        add_word(32'h7fff_ffff);
        add_word(32'h8000_0000);
        // top base, letter digits, negatives as raw patterns
        add_base(32'd36);
        add_word(32'd35);
        add_word(32'd36);
        add_word(32'hffff_ffff);
        add_word(32'h7fff_ffff);
        // write below the range clamps to two; longest texts
        add_base(32'd1);
        add_word(32'd0);
        add_word(32'd1);
        add_word(32'hffff_ffff);
        add_word(32'h8000_0000);
        add_word(32'haaaa_aaaa);
        add_base(32'd0);
        // write above the range clamps to thirty-six
        add_base(32'd63);
        // write to an unused index is ignored
        add_job(JOB_RADIX, ADDR_UNUSED, 32'd16);
        add_word(32'h5555_5555);
        add_word(32'd0);
        add_base(32'd37);
        // upper bits of the write are dropped
        add_base(32'hffff_ff10);
        add_word(32'd255);
        add_word(32'hffff_ffff);
        add_word(32'hdead_beef);
        add_base(32'd3);
        add_word(32'd8);

        // random phases, each setting a base and a pacing
        for (p = 0; p < 8; p++)
        begin
            if (p == 5)
            begin
                add_base($urandom);
            end
            else
            begin
                add_base(base_list[p]);
            end
            if (p == 3)
            begin
                add_job(JOB_RADIX, ADDR_UNUSED, $urandom);
            end
            add_job(JOB_PACE, ADDR_RADIX, pace_list[p % 3]);
            for (n = 0; n < 45; n++)
            begin
                if (n == 24)
                begin
                    add_job(JOB_DRAIN, ADDR_RADIX, 32'd0);
                end
                add_word(rand_word());
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sampled away from the driving edge
        while (work_list.size() != 0 || start || bus_phase != BUS_IDLE ||
               pending_chars.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending_chars.size() != 0)
        begin
            $display("%0d characters never arrived", pending_chars.size());
        end
        if (fault_count == 0 && pending_chars.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
